// ----- rtl/deque_ring_buffer_random_access_top_defines.svh -----
// ----------------------------------------------------------------------------
// deque ring buffer assertion macros
// concurrent checks, compiled away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef DEQUE_RING_BUFFER_RANDOM_ACCESS_TOP_DEFINES_SVH
`define DEQUE_RING_BUFFER_RANDOM_ACCESS_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define DQR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("dqr check failed");

// antecedent in one cycle implies consequent in the next
`define DQR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dqr sequencing check failed");

`else

`define DQR_ASSERT(lbl, clk, rst, prop)
`define DQR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/dqr_pkg.sv -----
// ----------------------------------------------------------------------------
// dqr_pkg
// command, status and sequencer types shared by the deque ring buffer
// ----------------------------------------------------------------------------
package dqr_pkg;

  // command codes carried in the input word
  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_RESIZE     = 3'd4,
    CMD_READ       = 3'd5,
    CMD_WRITE      = 3'd6,
    CMD_NOP        = 3'd7
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_FILL = 3'b100
  } fsm_t;

  // memory port strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ----- rtl/dqr_mem.sv -----
// ----------------------------------------------------------------------------
// dqr_mem
// element store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module dqr_mem
  import dqr_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  mem_ctl_t         ctl,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/dqr_ctrl.sv -----
// ----------------------------------------------------------------------------
// dqr_ctrl
// command sequencer: head and count registers, ring addressing, zero fill
// ----------------------------------------------------------------------------
module dqr_ctrl
  import dqr_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10,
  parameter int CW    = 11
) (
  input  logic             clk,
  input  logic             rst,
  // command word
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_cmd,
  input  logic [WIDTH-1:0] in_data,
  input  logic [AW-1:0]    in_pos,
  input  logic [CW-1:0]    in_len,
  // result buffer has a free slot
  input  logic             room,
  output logic             res_valid,
  output logic [WIDTH-1:0] res_value,
  output status_t          res_status,
  output logic [CW-1:0]    res_occ,
  output logic [CW-1:0]    occupancy_now,
  // memory port
  output mem_ctl_t         mem_ctl,
  output logic [AW-1:0]    mem_waddr,
  output logic [WIDTH-1:0] mem_wdata,
  output logic [AW-1:0]    mem_raddr,
  input  logic [WIDTH-1:0] mem_rdata
);

  localparam logic [CW:0]   DEPTH_W = (CW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  fsm_t          state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] fill_len;
  logic          grow_start;
  logic          acc;
  cmd_t          cmd;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] count_inc;

  // ring index of element at offset from the front
  function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] h,
                                              input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(off);
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign in_ready      = (state == S_IDLE) && room;
  assign acc           = in_valid && in_ready;
  assign cmd           = cmd_t'(in_cmd);
  assign pos_ext       = CW'(in_pos);
  assign count_inc     = count + CW'(1);
  assign occupancy_now = count;
  assign res_occ       = count_next;

  // command decode and sequencing
  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    grow_start = 1'b0;
    mem_ctl    = '0;
    mem_waddr  = ring_slot(head, count);
    mem_wdata  = in_data;
    mem_raddr  = ring_slot(head, pos_ext);
    res_valid  = 1'b0;
    res_value  = '0;
    res_status = STAT_OK;

    case (state)
      S_IDLE: begin
        if (acc) begin
          res_valid = 1'b1;
          case (cmd)
            CMD_PUSH_BACK: begin
              if (count == DEPTH_C) begin
                res_status = STAT_FULL;
              end else begin
                mem_ctl.wr_en = 1'b1;
                count_next    = count_inc;
              end
            end
            CMD_PUSH_FRONT: begin
              if (count == DEPTH_C) begin
                res_status = STAT_FULL;
              end else begin
                head_next     = (head == '0) ? LAST_SLOT : head - AW'(1);
                mem_ctl.wr_en = 1'b1;
                mem_waddr     = head_next;
                count_next    = count_inc;
              end
            end
            CMD_POP_FRONT: begin
              if (count == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                head_next  = (head == LAST_SLOT) ? '0 : head + AW'(1);
                count_next = count - CW'(1);
              end
            end
            CMD_POP_BACK: begin
              if (count == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            CMD_RESIZE: begin
              if (in_len > DEPTH_C) begin
                res_status = STAT_FULL;
              end else if (in_len > count) begin
                // zero fill runs one entry per cycle, result at the end
                res_valid  = 1'b0;
                grow_start = 1'b1;
                state_next = S_FILL;
              end else begin
                count_next = in_len;
              end
            end
            CMD_READ: begin
              if (pos_ext >= count) begin
                res_status = STAT_RANGE;
              end else begin
                res_valid      = 1'b0;
                mem_ctl.rd_en  = 1'b1;
                state_next     = S_READ;
              end
            end
            CMD_WRITE: begin
              if (pos_ext >= count) begin
                res_status = STAT_RANGE;
              end else begin
                mem_ctl.wr_en = 1'b1;
                mem_waddr     = mem_raddr;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_valid  = 1'b1;
        res_value  = mem_rdata;
        state_next = S_IDLE;
      end
      S_FILL: begin
        mem_ctl.wr_en = 1'b1;
        mem_wdata     = '0;
        count_next    = count_inc;
        if (count_inc == fill_len) begin
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  // target length of a growing resize
  always_ff @(posedge clk) begin
    if (grow_start) begin
      fill_len <= in_len;
    end
  end

endmodule

// ----- rtl/deque_ring_buffer_random_access_top.sv -----
// ----------------------------------------------------------------------------
// deque_ring_buffer_random_access_top
// double-ended queue in a ring memory with indexed read and write
// ----------------------------------------------------------------------------
// channel   dir  fields (tdata, lowest bit first)
// s_axis    in   cmd[2:0], data_value[WIDTH], position[AW], new_length[CW]
// m_axis    out  read_value[WIDTH], status[2], occupancy[CW]
//
// push, pop, write, shrinking resize, errors: result from S_IDLE as the word is taken
// read: S_IDLE then S_READ, through the registered read data of the element memory
// growing resize: new_length - occupancy zero writes in S_FILL, one zero write per
// cycle through the single write port
// reset clears state, head, count and the result buffer count; the element memory is not cleared
// a two-entry result buffer lets a word be taken while a result is stalled
// ----------------------------------------------------------------------------
`include "deque_ring_buffer_random_access_top_defines.svh"

module deque_ring_buffer_random_access_top
  import dqr_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW  = $clog2(DEPTH + 1),
  localparam int IW  = 3 + WIDTH + AW + CW,
  localparam int IBW = ((IW + 7) / 8) * 8,
  localparam int OW  = WIDTH + 2 + CW,
  localparam int OBW = ((OW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  // cmd, data_value, position, new_length
  input  logic [IBW-1:0] s_tdata,
  output logic           m_tvalid,
  input  logic           m_tready,
  // read_value, status, occupancy
  output logic [OBW-1:0] m_tdata
);

  logic [2:0]       in_cmd;
  logic [WIDTH-1:0] in_data;
  logic [AW-1:0]    in_pos;
  logic [CW-1:0]    in_len;

  logic             room;
  logic             res_valid;
  logic [WIDTH-1:0] res_value;
  status_t          res_status;
  logic [CW-1:0]    res_occ;
  logic [CW-1:0]    occupancy_now;

  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    mem_waddr;
  logic [WIDTH-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [WIDTH-1:0] mem_rdata;

  logic [OW-1:0]    res_word;
  logic [OW-1:0]    slot0;
  logic [OW-1:0]    slot1;
  logic [1:0]       ob_cnt;
  logic             pop;

  // unpack the input word
  assign in_cmd  = s_tdata[2:0];
  assign in_data = s_tdata[3 +: WIDTH];
  assign in_pos  = s_tdata[3 + WIDTH +: AW];
  assign in_len  = s_tdata[3 + WIDTH + AW +: CW];

  dqr_ctrl #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_cmd       (in_cmd),
    .in_data      (in_data),
    .in_pos       (in_pos),
    .in_len       (in_len),
    .room         (room),
    .res_valid    (res_valid),
    .res_value    (res_value),
    .res_status   (res_status),
    .res_occ      (res_occ),
    .occupancy_now(occupancy_now),
    .mem_ctl      (mem_ctl),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  dqr_mem #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .ctl  (mem_ctl),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // two-entry result buffer
  assign res_word = {res_occ, res_status, res_value};
  assign room     = (ob_cnt != 2'd2);
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (ob_cnt != 2'd0);
  assign m_tdata  = OBW'(slot0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_cnt <= 2'd0;
    end else begin
      ob_cnt <= ob_cnt + 2'(res_valid) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (ob_cnt == 2'd2)) begin
      slot0 <= slot1;
    end
    if (res_valid) begin
      if ((ob_cnt - 2'(pop)) == 2'd0) begin
        slot0 <= res_word;
      end else begin
        slot1 <= res_word;
      end
    end
  end

  // checks
  `DQR_ASSERT(a_no_overflow, clk, rst, !res_valid || room || pop)
  `DQR_ASSERT(a_count_bound, clk, rst, occupancy_now <= CW'(DEPTH))
  `DQR_ASSERT_NEXT(a_read_result, clk, rst, s_tvalid && s_tready && (in_cmd == CMD_READ) && (CW'(in_pos) < occupancy_now), res_valid)

endmodule
